FILE: sv/clr_pkg.sv
// Shared types, constants and helper functions for the console lockout responder.
package clr_pkg;

  // Widths of the configuration registers and the main stores.
  localparam int unsigned SEED_W = 8;
  localparam int unsigned CSUM_W = 48;
  localparam int unsigned CFG_W  = 48;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned WORD_W = 8;
  localparam int unsigned NIB_W  = 4;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_REGION   = 2'd0;
  localparam logic [1:0] CFG_SEED     = 2'd1;
  localparam logic [1:0] CFG_CHECKSUM = 2'd2;

  // Register reset values.
  localparam logic [SEED_W-1:0] SEED_RESET = 8'h3F;
  localparam logic [CSUM_W-1:0] CSUM_RESET = 48'hA536_C0F1_D859;

  // One request in and one result out.
  typedef struct packed {
    logic dio_in;
    logic cold_reset;
  } clr_in_t;

  typedef struct packed {
    logic drive_low;
    logic slot_is_write;
    logic halted;
  } clr_out_t;

  // Datapath operations, one per clock.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLEAR,
    OP_SHIFT_CLR,
    OP_SHIFT,
    OP_SHIFT_WRM,
    OP_SHIFT_WRC,
    OP_CMD_FIRST,
    OP_INIT_WR,
    OP_CSUM_WR,
    OP_IMG_WR,
    OP_ADD_LD,
    OP_ADD_STEP,
    OP_MIX_LD,
    OP_MIX1,
    OP_MIX2,
    OP_MIX3,
    OP_MIX4,
    OP_MIX5,
    OP_MIX6,
    OP_MIX7,
    OP_MIX8,
    OP_IDX_LD,
    OP_IDX_STEP,
    OP_XF_INIT,
    OP_XF_STEP
  } clr_op_e;

  typedef struct packed {
    clr_op_e             op;
    logic [ADDR_W-1:0]   addr;
    logic                din;
  } clr_cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0]   main_rd;
    logic [NIB_W-1:0]    chal_rd;
    logic [NIB_W-1:0]    shift;
    logic [ADDR_W-1:0]   idx;
    logic                b_wrap;
    logic                x_done;
  } clr_stat_t;

  // Fixed region images loaded after the checksum.
  localparam logic [NIB_W-1:0] IMG_NTSC [32] = '{
    4'hE, 4'h0, 4'h9, 4'hA, 4'h1, 4'h8, 4'h5, 4'hA, 4'h1, 4'h3, 4'hE,
    4'h1, 4'h0, 4'hD, 4'hE, 4'hC, 4'h0, 4'hB, 4'h1, 4'h4, 4'hF, 4'h8,
    4'hB, 4'h5, 4'h7, 4'hC, 4'hD, 4'h6, 4'h1, 4'hE, 4'h9, 4'h8
  };
  localparam logic [NIB_W-1:0] IMG_PAL [32] = '{
    4'hE, 4'h0, 4'h4, 4'hF, 4'h5, 4'h1, 4'h2, 4'h1, 4'h7, 4'h1, 4'h9,
    4'h8, 4'h5, 4'h7, 4'h5, 4'hA, 4'h0, 4'hB, 4'h1, 4'h2, 4'h3, 4'hF,
    4'h8, 4'h2, 4'h7, 4'h1, 4'h9, 4'h8, 4'h1, 4'h1, 4'h5, 4'hC
  };

  function automatic logic [NIB_W-1:0] img_nib(input logic pal, input logic [ADDR_W-1:0] a);
    img_nib = pal ? IMG_PAL[a] : IMG_NTSC[a];
  endfunction

  // Bit of a nibble sent in slot position k, most significant bit first.
  function automatic logic nib_bit(input logic [NIB_W-1:0] n, input logic [1:0] k);
    nib_bit = n[2'd3 - k];
  endfunction

endpackage

FILE: sv/clr_datapath.sv
// Datapath: main and challenge stores, round arithmetic, read shifter and compare pointer.
module clr_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         region_pal_i,
  input  logic [clr_pkg::SEED_W-1:0]   seed_value_i,
  input  logic [clr_pkg::CSUM_W-1:0]   checksum_i,
  input  clr_pkg::clr_cmd_t            cmd_i,
  output clr_pkg::clr_stat_t           stat_o
);
  import clr_pkg::*;

  logic [WORD_W-1:0] main_q [32];
  logic [NIB_W-1:0]  chal_q [32];

  logic [WORD_W-1:0] a_q, a_d, x_q, x_d;
  logic [3:0]        b_q, b_d;
  logic [NIB_W-1:0]  acc_q, acc_d, shift_q, shift_d;
  logic              carry_q, carry_d;
  logic [ADDR_W-1:0] idx_q, idx_d;

  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] m;
  logic [NIB_W-1:0]  c;
  logic              we_m, we_c;
  logic [WORD_W-1:0] wm;
  logic [NIB_W-1:0]  wc;
  logic [WORD_W-1:0] s;
  logic [NIB_W-1:0]  sh_next;
  logic [NIB_W-1:0]  csum_nib;
  logic [NIB_W-1:0]  init_nib;
  logic [3:0]        ci;
  logic [5:0]        csh;

  // Challenge transform step, all narrow values.
  logic [4:0]        xf_t0, xf_t1, xf_t3, xf_t4;
  logic [NIB_W-1:0]  xf_a2, xf_a3;

  // The fourth to seventh mix steps walk the upper half with their own pointer.
  assign rd_addr = (cmd_i.op == OP_MIX4 || cmd_i.op == OP_MIX5 ||
                    cmd_i.op == OP_MIX6 || cmd_i.op == OP_MIX7) ? {1'b1, b_q} : cmd_i.addr;
  assign m       = main_q[rd_addr];
  assign c       = chal_q[cmd_i.addr];
  assign sh_next = {shift_q[2:0], cmd_i.din};

  // Checksum nibble for addresses four to fifteen, first nibble at the top.
  assign ci       = cmd_i.addr[3:0] - 4'd4;
  assign csh      = 6'd44 - {ci, 2'b00};
  assign csum_nib = NIB_W'(checksum_i >> csh);

  // Seed image written while the store is swept clear.
  always_comb begin
    unique case (cmd_i.addr)
      5'h0A:        init_nib = 4'hB;
      5'h0B:        init_nib = 4'h5;
      5'h0C, 5'h0E: init_nib = seed_value_i[7:4];
      default:      init_nib = 4'h0;
    endcase
  end

  assign xf_t0 = {1'b0, acc_q} + (c[0] ? 5'd0 : 5'd8);
  assign xf_t1 = xf_t0 + (xf_t0[1] ? 5'd0 : 5'd4);
  assign xf_a2 = xf_t1[3:0] + c;
  assign xf_t3 = {1'b0, xf_a2} + (carry_q ? 5'd0 : 5'd7);
  assign xf_a3 = xf_t3[3:0] + xf_a2;
  assign xf_t4 = {1'b0, xf_a3} + {1'b0, xf_a2} + {4'b0, carry_q};

  // Operation decode.
  always_comb begin
    a_d     = a_q;
    x_d     = x_q;
    b_d     = b_q;
    acc_d   = acc_q;
    carry_d = carry_q;
    shift_d = shift_q;
    idx_d   = idx_q;
    we_m    = 1'b0;
    we_c    = 1'b0;
    wm      = '0;
    wc      = '0;
    s       = '0;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        shift_d = '0;
        idx_d   = '0;
      end
      OP_SHIFT_CLR: shift_d = '0;
      OP_SHIFT:     shift_d = sh_next;
      OP_SHIFT_WRM: begin
        shift_d = sh_next;
        we_m    = 1'b1;
        wm      = {4'b0, sh_next};
      end
      OP_SHIFT_WRC: begin
        shift_d = sh_next;
        we_c    = 1'b1;
        wc      = sh_next;
      end
      OP_CMD_FIRST: shift_d = {3'b0, cmd_i.din};
      OP_INIT_WR: begin
        we_m = 1'b1;
        if (cmd_i.addr == 5'h0D || cmd_i.addr == 5'h0F) begin
          wm = seed_value_i;
        end else begin
          wm = {4'b0, init_nib};
        end
      end
      OP_CSUM_WR: begin
        we_m = 1'b1;
        wm   = {4'b0, csum_nib};
      end
      OP_IMG_WR: begin
        we_m = 1'b1;
        wm   = {4'b0, img_nib(region_pal_i, cmd_i.addr)};
      end
      OP_ADD_LD: a_d = m;
      OP_ADD_STEP: begin
        s    = {4'b0, a_q[3:0] + 4'd1 + m[3:0]};
        we_m = 1'b1;
        wm   = s;
        a_d  = s;
      end
      OP_MIX_LD: begin
        a_d = m;
        x_d = m;
      end
      OP_MIX1: begin
        s    = a_q + m + 8'd1;
        we_m = 1'b1;
        wm   = s;
        a_d  = s;
      end
      OP_MIX2: begin
        s    = a_q + m + 8'd1;
        we_m = 1'b1;
        wm   = ~s;
        a_d  = {4'b0, m[3:0]};
        b_d  = 4'd3;
      end
      OP_MIX3: begin
        s = a_q + {4'b0, m[3:0]} + 8'd1;
        if (s < 8'd16) begin
          we_m = 1'b1;
          wm   = s;
          a_d  = m;
          b_d  = 4'd4;
        end else begin
          a_d = s;
          b_d = 4'd3;
        end
      end
      OP_MIX4: begin
        s    = a_q + m;
        we_m = 1'b1;
        wm   = s;
        a_d  = s;
        b_d  = b_q + 4'd1;
      end
      OP_MIX5: begin
        s    = a_q + m;
        we_m = 1'b1;
        wm   = s;
        a_d  = m;
        b_d  = b_q + 4'd1;
      end
      OP_MIX6: begin
        s = {4'b0, a_q[3:0]} + 8'd8;
        if (s < 8'd16) begin
          s = s + m;
        end
        we_m = 1'b1;
        wm   = s;
        a_d  = m;
        b_d  = b_q + 4'd1;
      end
      OP_MIX7: begin
        s    = a_q + m + 8'd1;
        we_m = 1'b1;
        wm   = s;
        a_d  = s;
        b_d  = b_q + 4'd1;
      end
      OP_MIX8: begin
        s   = x_q + 8'h0F;
        a_d = s;
        x_d = {4'b0, s[3:0]};
      end
      OP_IDX_LD: idx_d = {1'b1, (m[3:0] == 4'd0) ? 4'd1 : m[3:0]};
      OP_IDX_STEP: idx_d = region_pal_i ? idx_q - 5'd1 : idx_q + 5'd1;
      OP_XF_INIT: begin
        acc_d   = 4'd5;
        carry_d = 1'b1;
      end
      OP_XF_STEP: begin
        carry_d = xf_t4[4];
        acc_d   = ~xf_t4[3:0];
        we_c    = 1'b1;
        wc      = ~xf_t4[3:0];
      end
      default: begin
      end
    endcase
  end

  // Control registers of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      idx_q   <= '0;
    end else begin
      shift_q <= shift_d;
      idx_q   <= idx_d;
    end
  end

  // Working registers of the rounds.
  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    x_q     <= x_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    carry_q <= carry_d;
  end

  // Stores, one write each per clock.
  always_ff @(posedge clk_i) begin
    if (we_m) begin
      main_q[rd_addr] <= wm;
    end
    if (we_c) begin
      chal_q[cmd_i.addr] <= wc;
    end
  end

  assign stat_o.main_rd = m;
  assign stat_o.chal_rd = c;
  assign stat_o.shift   = shift_q;
  assign stat_o.idx     = idx_q;
  assign stat_o.b_wrap  = (b_q == 4'hF);
  assign stat_o.x_done  = (x_q[3:0] == 4'h0);

endmodule

FILE: sv/clr_ctrl.sv
// Controller: protocol phase, slot counter, round sequencer and result register.
module clr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 region_pal_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  clr_pkg::clr_in_t     in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output clr_pkg::clr_out_t    out_data_o,
  output clr_pkg::clr_cmd_t    cmd_o,
  input  clr_pkg::clr_stat_t   stat_i
);
  import clr_pkg::*;

  // Sequencer states.
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_EVAL     = 5'd1;
  localparam logic [4:0] S_DONE     = 5'd2;
  localparam logic [4:0] S_INIT_CLR = 5'd3;
  localparam logic [4:0] S_ADD_LD   = 5'd4;
  localparam logic [4:0] S_ADD_STEP = 5'd5;
  localparam logic [4:0] S_CSUM_WR  = 5'd6;
  localparam logic [4:0] S_IMG_WR   = 5'd7;
  localparam logic [4:0] S_MIX_LD   = 5'd8;
  localparam logic [4:0] S_MIX1     = 5'd9;
  localparam logic [4:0] S_MIX2     = 5'd10;
  localparam logic [4:0] S_MIX3     = 5'd11;
  localparam logic [4:0] S_MIX4     = 5'd12;
  localparam logic [4:0] S_MIX5     = 5'd13;
  localparam logic [4:0] S_MIX6     = 5'd14;
  localparam logic [4:0] S_MIX7     = 5'd15;
  localparam logic [4:0] S_MIX8     = 5'd16;
  localparam logic [4:0] S_IDX_LD   = 5'd17;
  localparam logic [4:0] S_XF_INIT  = 5'd18;
  localparam logic [4:0] S_XF_STEP  = 5'd19;

  // Protocol phases.
  localparam logic [3:0] PH_WAIT   = 4'd0;
  localparam logic [3:0] PH_HELLO  = 4'd1;
  localparam logic [3:0] PH_SEED   = 4'd2;
  localparam logic [3:0] PH_MARK   = 4'd3;
  localparam logic [3:0] PH_CSUM   = 4'd4;
  localparam logic [3:0] PH_INITRD = 4'd5;
  localparam logic [3:0] PH_CMD    = 4'd6;
  localparam logic [3:0] PH_CMPRD  = 4'd7;
  localparam logic [3:0] PH_CMPWR  = 4'd8;
  localparam logic [3:0] PH_XAA    = 4'd9;
  localparam logic [3:0] PH_XRD    = 4'd10;
  localparam logic [3:0] PH_XMARK  = 4'd11;
  localparam logic [3:0] PH_XWR    = 4'd12;
  localparam logic [3:0] PH_RSTBIT = 4'd13;
  localparam logic [3:0] PH_HALT   = 4'd14;

  // Command codes formed from the two command bits.
  localparam logic [1:0] CMD_COMPARE   = 2'd0;
  localparam logic [1:0] CMD_DIE       = 2'd1;
  localparam logic [1:0] CMD_CHALLENGE = 2'd2;
  localparam logic [1:0] CMD_RESET     = 2'd3;

  logic [4:0]        st_q, st_d;
  logic [3:0]        ph_q, ph_d;
  logic [6:0]        cnt_q, cnt_d;
  logic [ADDR_W-1:0] uc_q, uc_d;
  logic [1:0]        rnd_q, rnd_d;
  logic              add_hi_q, add_hi_d;
  logic              stop_q, stop_d;
  logic              din_q, cold_q;
  clr_out_t          res_q, res_d;
  logic              out_valid_q, out_valid_d;
  clr_out_t          out_q, out_d;

  logic              wr, bit_val;
  logic [1:0]        kb;
  logic [ADDR_W-1:0] kn;
  logic [6:0]        cnt_inc;
  logic [ADDR_W-1:0] nidx;
  logic [NIB_W-1:0]  hello;
  logic [1:0]        code;

  assign kb      = cnt_q[1:0];
  assign kn      = cnt_q[6:2];
  assign cnt_inc = cnt_q + 7'd1;
  assign hello   = region_pal_i ? 4'h5 : 4'h1;
  assign nidx    = region_pal_i ? stat_i.idx - 5'd1 : stat_i.idx + 5'd1;
  assign code    = {stat_i.shift[0], din_q};

  // Slot evaluation and round sequencing.
  always_comb begin
    st_d      = st_q;
    ph_d      = ph_q;
    cnt_d     = cnt_q;
    uc_d      = uc_q;
    rnd_d     = rnd_q;
    add_hi_d  = add_hi_q;
    stop_d    = stop_q;
    res_d     = res_q;
    wr        = 1'b0;
    bit_val   = 1'b1;
    cmd_o.op   = OP_NOP;
    cmd_o.addr = '0;
    cmd_o.din  = din_q;
    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          st_d = S_EVAL;
        end
      end
      S_EVAL: begin
        st_d = S_DONE;
        if (cold_q) begin
          ph_d     = PH_WAIT;
          cnt_d    = '0;
          stop_d   = 1'b0;
          cmd_o.op = OP_CLEAR;
        end else begin
          unique case (ph_q)
            PH_WAIT: begin
              wr      = 1'b1;
              bit_val = nib_bit(hello, 2'd0);
              cnt_d   = 7'd1;
              ph_d    = PH_HELLO;
              uc_d    = '0;
              st_d    = S_INIT_CLR;
            end
            PH_HELLO: begin
              wr      = 1'b1;
              bit_val = nib_bit(hello, kb);
              if (cnt_q == 7'd3) begin
                ph_d  = PH_SEED;
                cnt_d = '0;
              end else begin
                cnt_d = cnt_inc;
              end
            end
            PH_SEED: begin
              wr         = 1'b1;
              cmd_o.addr = 5'h0A + kn;
              bit_val    = nib_bit(stat_i.main_rd[3:0], kb);
              if (cnt_q == 7'd23) begin
                ph_d  = PH_MARK;
                cnt_d = '0;
                uc_d  = 5'd4;
                st_d  = S_CSUM_WR;
              end else begin
                cnt_d = cnt_inc;
              end
            end
            PH_MARK: begin
              wr      = 1'b1;
              bit_val = 1'b0;
              ph_d    = PH_CSUM;
              cnt_d   = '0;
            end
            PH_CSUM: begin
              wr         = 1'b1;
              cmd_o.addr = kn;
              bit_val    = nib_bit(stat_i.main_rd[3:0], kb);
              if (cnt_q == 7'd63) begin
                ph_d     = PH_INITRD;
                cnt_d    = '0;
                cmd_o.op = OP_SHIFT_CLR;
                uc_d     = '0;
                st_d     = S_IMG_WR;
              end else begin
                cnt_d = cnt_inc;
              end
            end
            PH_INITRD: begin
              if (cnt_q == 7'd3) begin
                cmd_o.op   = OP_SHIFT_WRM;
                cmd_o.addr = 5'h01;
              end else if (cnt_q == 7'd7) begin
                cmd_o.op   = OP_SHIFT_WRM;
                cmd_o.addr = 5'h11;
              end else begin
                cmd_o.op = OP_SHIFT;
              end
              if (cnt_q == 7'd7) begin
                ph_d  = PH_CMD;
                cnt_d = '0;
              end else begin
                cnt_d = cnt_inc;
              end
            end
            PH_CMD: begin
              if (cnt_q == 7'd0) begin
                cmd_o.op = OP_CMD_FIRST;
                cnt_d    = 7'd1;
              end else begin
                cnt_d = '0;
                unique case (code)
                  CMD_COMPARE: begin
                    ph_d  = PH_CMPRD;
                    rnd_d = 2'd2;
                    st_d  = S_MIX_LD;
                  end
                  CMD_CHALLENGE: ph_d = PH_XAA;
                  CMD_RESET:     ph_d = PH_RSTBIT;
                  CMD_DIE: begin
                    stop_d = 1'b1;
                    ph_d   = PH_HALT;
                  end
                  default: ph_d = PH_HALT;
                endcase
              end
            end
            PH_CMPRD: ph_d = PH_CMPWR;
            PH_CMPWR: begin
              wr         = 1'b1;
              cmd_o.addr = stat_i.idx;
              cmd_o.op   = OP_IDX_STEP;
              bit_val    = stat_i.main_rd[0];
              ph_d       = (nidx[3:0] != 4'd0) ? PH_CMPRD : PH_CMD;
            end
            PH_XAA: begin
              wr      = 1'b1;
              bit_val = nib_bit(4'hA, kb);
              if (cnt_q == 7'd7) begin
                ph_d     = PH_XRD;
                cnt_d    = '0;
                cmd_o.op = OP_SHIFT_CLR;
              end else begin
                cnt_d = cnt_inc;
              end
            end
            PH_XRD: begin
              cmd_o.op   = (kb == 2'd3) ? OP_SHIFT_WRC : OP_SHIFT;
              cmd_o.addr = kn;
              if (cnt_q == 7'd119) begin
                ph_d  = PH_XMARK;
                cnt_d = '0;
                st_d  = S_XF_INIT;
              end else begin
                cnt_d = cnt_inc;
              end
            end
            PH_XMARK: begin
              wr      = 1'b1;
              bit_val = 1'b0;
              ph_d    = PH_XWR;
              cnt_d   = '0;
            end
            PH_XWR: begin
              wr         = 1'b1;
              cmd_o.addr = kn;
              bit_val    = nib_bit(stat_i.chal_rd, kb);
              if (cnt_q == 7'd119) begin
                ph_d  = PH_CMD;
                cnt_d = '0;
              end else begin
                cnt_d = cnt_inc;
              end
            end
            PH_RSTBIT: begin
              wr      = 1'b1;
              bit_val = 1'b0;
              ph_d    = PH_CMD;
              cnt_d   = '0;
            end
            default: begin
              stop_d = 1'b1;
              ph_d   = PH_HALT;
            end
          endcase
        end
        res_d.drive_low     = wr & ~bit_val;
        res_d.slot_is_write = wr;
        res_d.halted        = stop_d;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          st_d = S_IDLE;
        end
      end
      S_INIT_CLR: begin
        cmd_o.op   = OP_INIT_WR;
        cmd_o.addr = uc_q;
        uc_d       = uc_q + 5'd1;
        if (uc_q == 5'd31) begin
          add_hi_d = 1'b1;
          rnd_d    = 2'd1;
          st_d     = S_ADD_LD;
        end
      end
      S_CSUM_WR: begin
        cmd_o.op   = OP_CSUM_WR;
        cmd_o.addr = uc_q;
        uc_d       = uc_q + 5'd1;
        if (uc_q == 5'd15) begin
          add_hi_d = 1'b0;
          rnd_d    = 2'd3;
          st_d     = S_ADD_LD;
        end
      end
      S_ADD_LD: begin
        cmd_o.op   = OP_ADD_LD;
        cmd_o.addr = add_hi_q ? 5'h0A : 5'h00;
        uc_d       = cmd_o.addr + 5'd1;
        st_d       = S_ADD_STEP;
      end
      S_ADD_STEP: begin
        cmd_o.op   = OP_ADD_STEP;
        cmd_o.addr = uc_q;
        uc_d       = uc_q + 5'd1;
        if (uc_q[3:0] == 4'hF) begin
          if (rnd_q == 2'd0) begin
            st_d = S_DONE;
          end else begin
            rnd_d = rnd_q - 2'd1;
            st_d  = S_ADD_LD;
          end
        end
      end
      S_IMG_WR: begin
        cmd_o.op   = OP_IMG_WR;
        cmd_o.addr = uc_q;
        uc_d       = uc_q + 5'd1;
        if (uc_q == 5'd31) begin
          st_d = S_DONE;
        end
      end
      S_MIX_LD: begin
        cmd_o.op   = OP_MIX_LD;
        cmd_o.addr = 5'h1F;
        st_d       = S_MIX1;
      end
      S_MIX1: begin
        cmd_o.op   = OP_MIX1;
        cmd_o.addr = 5'h11;
        st_d       = S_MIX2;
      end
      S_MIX2: begin
        cmd_o.op   = OP_MIX2;
        cmd_o.addr = 5'h12;
        st_d       = S_MIX3;
      end
      S_MIX3: begin
        cmd_o.op   = OP_MIX3;
        cmd_o.addr = 5'h13;
        st_d       = S_MIX4;
      end
      S_MIX4: begin
        cmd_o.op = OP_MIX4;
        st_d     = S_MIX5;
      end
      S_MIX5: begin
        cmd_o.op = OP_MIX5;
        st_d     = S_MIX6;
      end
      S_MIX6: begin
        cmd_o.op = OP_MIX6;
        st_d     = S_MIX7;
      end
      S_MIX7: begin
        cmd_o.op = OP_MIX7;
        if (stat_i.b_wrap) begin
          st_d = S_MIX8;
        end
      end
      S_MIX8: begin
        cmd_o.op = OP_MIX8;
        if (stat_i.x_done) begin
          if (rnd_q == 2'd0) begin
            st_d = S_IDX_LD;
          end else begin
            rnd_d = rnd_q - 2'd1;
            st_d  = S_MIX_LD;
          end
        end else begin
          st_d = S_MIX1;
        end
      end
      S_IDX_LD: begin
        cmd_o.op   = OP_IDX_LD;
        cmd_o.addr = 5'h17;
        st_d       = S_DONE;
      end
      S_XF_INIT: begin
        cmd_o.op = OP_XF_INIT;
        uc_d     = '0;
        st_d     = S_XF_STEP;
      end
      S_XF_STEP: begin
        cmd_o.op   = OP_XF_STEP;
        cmd_o.addr = uc_q;
        uc_d       = uc_q + 5'd1;
        if (uc_q == 5'd29) begin
          st_d = S_DONE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Output register: a finished result waits here while the next request comes in.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (st_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      ph_q        <= PH_WAIT;
      cnt_q       <= '0;
      uc_q        <= '0;
      rnd_q       <= '0;
      add_hi_q    <= 1'b0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      ph_q        <= ph_d;
      cnt_q       <= cnt_d;
      uc_q        <= uc_d;
      rnd_q       <= rnd_d;
      add_hi_q    <= add_hi_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && in_valid_i) begin
      din_q  <= in_data_i.dio_in;
      cold_q <= in_data_i.cold_reset;
    end
    res_q <= res_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // A request taken always moves the controller to slot evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> st_q == S_EVAL)
    else $error("accepted request not evaluated");

  // The halted flag clears only by cold reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q && !(st_q == S_EVAL && cold_q) |=> stop_q)
    else $error("halted flag dropped without cold reset");

  // Once halted the block only reads.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.halted |-> !out_data_o.slot_is_write)
    else $error("transmit slot while halted");

  // The line is only pulled low in a transmit slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.drive_low |-> out_data_o.slot_is_write)
    else $error("drive low in a read slot");
`endif

endmodule

FILE: sv/console_lockout_responder.sv
// Top level of the console lockout responder: configuration registers and the two halves.
//
// Each request is one data-clock bit slot and yields one result saying whether the
// block pulls the data line low. A plain slot goes from request to result through
// the take, evaluate and hand-over states. Slots that end a protocol stage run the
// round sequencer on the single-port stores before the result is released: the
// first slot after cold reset, the last seed bit, the last checksum bit, the last
// challenge nibble, and a compare command (three mix rounds of up to sixteen passes
// each, plus the pointer load). A new request is taken while an earlier result
// still waits in the output register.
module console_lockout_responder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  clr_pkg::clr_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output clr_pkg::clr_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [clr_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import clr_pkg::*;

  logic              region_pal_q;
  logic [SEED_W-1:0] seed_q;
  logic [CSUM_W-1:0] csum_q;
  clr_cmd_t          cmd;
  clr_stat_t         stat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_pal_q <= 1'b0;
      seed_q       <= SEED_RESET;
      csum_q       <= CSUM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REGION:   region_pal_q <= cfg_wdata_i[0];
        CFG_SEED:     seed_q       <= cfg_wdata_i[SEED_W-1:0];
        CFG_CHECKSUM: csum_q       <= cfg_wdata_i[CSUM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  clr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .region_pal_i (region_pal_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .cmd_o        (cmd),
    .stat_i       (stat)
  );

  clr_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .region_pal_i (region_pal_q),
    .seed_value_i (seed_q),
    .checksum_i   (csum_q),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule
